// File: rtl/core/vrt_pkg.sv
// shared types and constants for the voxel ray traversal block
// payload structs, step codes, controller/datapath command and status
// no dependencies
package vrt_pkg;

  localparam int unsigned COORD_W = 16;
  localparam int unsigned FIX_W   = 32;
  localparam int unsigned DIR_W   = 16;
  localparam int unsigned NUM_AXES = 3;

  // six divisions per ray: boundary and per-cell distance for each axis
  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int unsigned JOB_W     = 3;
  localparam logic [JOB_W-1:0] LAST_JOB = JOB_W'(2 * NUM_AXES - 1);

  localparam logic [FIX_W-1:0] SAT_MAX   = '1;
  localparam logic [FIX_W-1:0] DELTA_NUM = FIX_W'(64'h8000_0000);

  localparam logic [1:0] STEP_NONE = 2'b00;
  localparam logic [1:0] STEP_POS  = 2'b01;
  localparam logic [1:0] STEP_NEG  = 2'b11;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  typedef enum logic [1:0] {
    AXIS_X    = 2'd0,
    AXIS_Y    = 2'd1,
    AXIS_Z    = 2'd2,
    AXIS_NONE = 2'd3
  } axis_t;

  typedef struct packed {
    logic                      command;
    logic signed [FIX_W-1:0]   origin_x;
    logic signed [FIX_W-1:0]   origin_y;
    logic signed [FIX_W-1:0]   origin_z;
    logic signed [DIR_W-1:0]   dir_x;
    logic signed [DIR_W-1:0]   dir_y;
    logic signed [DIR_W-1:0]   dir_z;
  } req_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] cell_x;
    logic signed [COORD_W-1:0] cell_y;
    logic signed [COORD_W-1:0] cell_z;
    axis_t                     crossed_axis;
  } rsp_t;

  typedef struct packed {
    logic             accept_start;
    logic             accept_step;
    logic             div_start;
    logic             wr_result;
    logic [JOB_W-1:0] job;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_status_t;

endpackage

// File: rtl/core/vrt_div.sv
// restoring unsigned divider, one quotient bit per cycle
// 32-bit dividend, 16-bit divisor; uses vrt_pkg
module vrt_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [vrt_pkg::FIX_W-1:0]  dividend,
  input  logic [vrt_pkg::DIR_W-1:0]  divisor,
  output logic                       done,
  output logic [vrt_pkg::FIX_W-1:0]  quotient
);

  logic                            busy;
  logic [vrt_pkg::DIV_CNT_W-1:0]   cnt;
  logic [vrt_pkg::DIR_W-1:0]       rem;
  logic [vrt_pkg::FIX_W-1:0]       quo;
  logic [vrt_pkg::DIR_W:0]         shifted;
  logic [vrt_pkg::DIR_W:0]         diff;
  logic                            fits;

  always_comb begin
    shifted = {rem, quo[vrt_pkg::FIX_W-1]};
    diff    = shifted - {1'b0, divisor};
    fits    = shifted >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == vrt_pkg::DIV_CNT_W'(vrt_pkg::DIV_STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      cnt <= '0;
    end else if (busy) begin
      // remainder stays below the divisor, so the difference fits
      rem <= fits ? diff[vrt_pkg::DIR_W-1:0] : shifted[vrt_pkg::DIR_W-1:0];
      quo <= {quo[vrt_pkg::FIX_W-2:0], fits};
      cnt <= cnt + 1'b1;
    end
  end

  assign quotient = quo;

endmodule

// File: rtl/core/vrt_datapath.sv
// traversal state, step logic, result register and divider feed
// uses vrt_pkg and vrt_div
module vrt_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  vrt_pkg::req_t        req,
  input  vrt_pkg::dp_cmd_t     cmd,
  output vrt_pkg::dp_status_t  status,
  output vrt_pkg::rsp_t        rsp
);

  localparam int unsigned N = vrt_pkg::NUM_AXES;

  logic [vrt_pkg::COORD_W-1:0] cur     [N];
  logic [1:0]                  code    [N];
  logic [vrt_pkg::FIX_W-1:0]   nb      [N];
  logic [vrt_pkg::FIX_W-1:0]   pcd     [N];
  logic [vrt_pkg::DIR_W-1:0]   frac    [N];
  logic [vrt_pkg::DIR_W-1:0]   mag     [N];
  logic                        neg     [N];

  logic [vrt_pkg::FIX_W-1:0]   org_in  [N];
  logic [vrt_pkg::DIR_W-1:0]   dir_in  [N];
  logic [vrt_pkg::DIR_W-1:0]   mag_in  [N];
  logic [vrt_pkg::COORD_W-1:0] cur_next[N];

  vrt_pkg::axis_t              win;
  logic [1:0]                  win_idx;
  logic [vrt_pkg::FIX_W-1:0]   win_nb;
  logic [vrt_pkg::FIX_W-1:0]   win_pcd;
  logic [vrt_pkg::FIX_W:0]     sum;
  logic [vrt_pkg::FIX_W-1:0]   nb_adv;

  logic [1:0]                  job_axis;
  logic [vrt_pkg::DIR_W-1:0]   job_frac;
  logic [vrt_pkg::DIR_W-1:0]   job_mag;
  logic                        job_neg;
  logic [vrt_pkg::DIR_W:0]     num;
  logic [vrt_pkg::FIX_W-1:0]   dividend;
  logic                        div_done;
  logic [vrt_pkg::FIX_W-1:0]   quotient;

  always_comb begin
    org_in[0] = req.origin_x;
    org_in[1] = req.origin_y;
    org_in[2] = req.origin_z;
    dir_in[0] = req.dir_x;
    dir_in[1] = req.dir_y;
    dir_in[2] = req.dir_z;
    for (int i = 0; i < N; i++) begin
      mag_in[i] = dir_in[i][vrt_pkg::DIR_W-1] ? -dir_in[i] : dir_in[i];
    end
  end

  // axis choice: x only when strictly smallest, then y over z, ties to z
  always_comb begin
    if (nb[0] < nb[1] && nb[0] < nb[2]) begin
      win     = vrt_pkg::AXIS_X;
      win_idx = 2'd0;
    end else if (nb[1] < nb[2]) begin
      win     = vrt_pkg::AXIS_Y;
      win_idx = 2'd1;
    end else begin
      win     = vrt_pkg::AXIS_Z;
      win_idx = 2'd2;
    end
    case (win_idx)
      2'd0: begin
        win_nb  = nb[0];
        win_pcd = pcd[0];
      end
      2'd1: begin
        win_nb  = nb[1];
        win_pcd = pcd[1];
      end
      default: begin
        win_nb  = nb[2];
        win_pcd = pcd[2];
      end
    endcase
    sum    = {1'b0, win_nb} + {1'b0, win_pcd};
    nb_adv = sum[vrt_pkg::FIX_W] ? vrt_pkg::SAT_MAX : sum[vrt_pkg::FIX_W-1:0];
    for (int i = 0; i < N; i++) begin
      cur_next[i] = cur[i];
      if (win_idx == 2'(i)) begin
        case (code[i])
          vrt_pkg::STEP_POS: cur_next[i] = cur[i] + 1'b1;
          vrt_pkg::STEP_NEG: cur_next[i] = cur[i] - 1'b1;
          default:           cur_next[i] = cur[i];
        endcase
      end
    end
  end

  // divider operands for the current job
  always_comb begin
    job_axis = cmd.job[vrt_pkg::JOB_W-1:1];
    case (job_axis)
      2'd0: begin
        job_frac = frac[0];
        job_mag  = mag[0];
        job_neg  = neg[0];
      end
      2'd1: begin
        job_frac = frac[1];
        job_mag  = mag[1];
        job_neg  = neg[1];
      end
      default: begin
        job_frac = frac[2];
        job_mag  = mag[2];
        job_neg  = neg[2];
      end
    endcase
    num = job_neg ? {1'b0, job_frac} : (17'h1_0000 - {1'b0, job_frac});
    // numerator shifted up by 15 fits exactly in 32 bits
    dividend = cmd.job[0] ? vrt_pkg::DELTA_NUM : {num, 15'b0};
  end

  vrt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (job_mag),
    .done     (div_done),
    .quotient (quotient)
  );

  assign status.div_done = div_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < N; i++) begin
        cur[i]  <= '0;
        code[i] <= vrt_pkg::STEP_NONE;
        nb[i]   <= vrt_pkg::SAT_MAX;
        pcd[i]  <= vrt_pkg::SAT_MAX;
      end
    end else if (cmd.accept_start) begin
      for (int i = 0; i < N; i++) begin
        cur[i] <= org_in[i][vrt_pkg::FIX_W-1 -: vrt_pkg::COORD_W];
        nb[i]  <= vrt_pkg::SAT_MAX;
        pcd[i] <= vrt_pkg::SAT_MAX;
        if (mag_in[i] == '0) begin
          code[i] <= vrt_pkg::STEP_NONE;
        end else if (dir_in[i][vrt_pkg::DIR_W-1]) begin
          code[i] <= vrt_pkg::STEP_NEG;
        end else begin
          code[i] <= vrt_pkg::STEP_POS;
        end
      end
    end else if (cmd.accept_step) begin
      for (int i = 0; i < N; i++) begin
        cur[i] <= cur_next[i];
        if (win_idx == 2'(i)) begin
          nb[i] <= nb_adv;
        end
      end
    end else if (cmd.wr_result) begin
      // zero-direction axes keep their saturated distances
      for (int i = 0; i < N; i++) begin
        if (job_axis == 2'(i) && mag[i] != '0) begin
          if (cmd.job[0]) begin
            pcd[i] <= quotient;
          end else begin
            nb[i] <= quotient;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept_start) begin
      for (int i = 0; i < N; i++) begin
        frac[i] <= org_in[i][vrt_pkg::DIR_W-1:0];
        mag[i]  <= mag_in[i];
        neg[i]  <= dir_in[i][vrt_pkg::DIR_W-1];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.accept_start) begin
      rsp.cell_x       <= req.origin_x[vrt_pkg::FIX_W-1 -: vrt_pkg::COORD_W];
      rsp.cell_y       <= req.origin_y[vrt_pkg::FIX_W-1 -: vrt_pkg::COORD_W];
      rsp.cell_z       <= req.origin_z[vrt_pkg::FIX_W-1 -: vrt_pkg::COORD_W];
      rsp.crossed_axis <= vrt_pkg::AXIS_NONE;
    end else if (cmd.accept_step) begin
      rsp.cell_x       <= cur_next[0];
      rsp.cell_y       <= cur_next[1];
      rsp.cell_z       <= cur_next[2];
      rsp.crossed_axis <= win;
    end
  end

endmodule

// File: rtl/core/vrt_ctrl.sv
// controller: input/output handshake and the division sequence of a start
// uses vrt_pkg
module vrt_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  input  logic                 req_command,
  output logic                 req_stall,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output vrt_pkg::dp_cmd_t     cmd,
  input  vrt_pkg::dp_status_t  status
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_LOAD = 3'b010,
    ST_WAIT = 3'b100
  } state_t;

  state_t                    state;
  state_t                    state_next;
  logic [vrt_pkg::JOB_W-1:0] job;
  logic                      out_free;
  logic                      accept;

  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = (state != ST_IDLE) || !out_free;
  assign accept    = req_valid && !req_stall;

  always_comb begin
    cmd.accept_start = accept && req_command == vrt_pkg::CMD_START;
    cmd.accept_step  = accept && req_command == vrt_pkg::CMD_STEP;
    cmd.div_start    = state == ST_LOAD;
    cmd.wr_result    = state == ST_WAIT && status.div_done;
    cmd.job          = job;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd.accept_start) state_next = ST_LOAD;
      end
      ST_LOAD: state_next = ST_WAIT;
      ST_WAIT: begin
        if (status.div_done) state_next = (job == vrt_pkg::LAST_JOB) ? ST_IDLE : ST_LOAD;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      job       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.accept_start) begin
        job <= '0;
      end else if (cmd.wr_result) begin
        job <= job + 1'b1;
      end
      if (accept) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> req_stall)
    else $error("input taken while divisions run");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    status.div_done |-> state == ST_WAIT)
    else $error("divider finished outside wait state");

  a_job_range: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> job <= vrt_pkg::LAST_JOB)
    else $error("division job out of range");

  a_result_kept: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid)
    else $error("stalled result dropped");

  a_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state))
    else $error("state register not one-hot");

endmodule

// File: rtl/core/voxel_ray_traversal.sv
// top level of the 3d voxel ray traversal block
// uses vrt_pkg, vrt_ctrl, vrt_datapath (which holds vrt_div)
//
// A step command (command = 1) moves one cell along the axis with the smallest
// boundary distance; its result is valid the cycle after the transfer and
// back-to-back steps run at one per clock while the output is not stalled. A
// start command (command = 0) returns its result (cell = floor of the origin,
// crossed_axis = none) in the cycle after the transfer, then the input stalls
// while one shared bit-serial divider computes the six ray parameters
// (boundary and per-cell distance for each axis). A result register sits
// between the input and output sides: the next command is taken in the cycle
// the held result transfers, and a stalled result stalls the input.
module voxel_ray_traversal (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  vrt_pkg::req_t  req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output vrt_pkg::rsp_t  rsp
);

  vrt_pkg::dp_cmd_t    cmd;
  vrt_pkg::dp_status_t status;

  vrt_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_command (req.command),
    .req_stall   (req_stall),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .cmd         (cmd),
    .status      (status)
  );

  vrt_datapath u_dp (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .cmd    (cmd),
    .status (status),
    .rsp    (rsp)
  );

endmodule
